/* src/mep_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_pkg
// Shared types, register indexes, palette and saturation helper for the
// escape-time pixel colouring block.
// ----------------------------------------------------------------------------
package mep_pkg;

  typedef enum logic [2:0] {
    REG_REAL_ORIGIN     = 3'd0,
    REG_IMAG_ORIGIN     = 3'd1,
    REG_STEP_REAL       = 3'd2,
    REG_STEP_IMAG       = 3'd3,
    REG_ITERATION_LIMIT = 3'd4
  } mep_reg_t;

  localparam logic signed [31:0] RESET_REAL_ORIGIN     = -32'sd167772160;
  localparam logic signed [31:0] RESET_IMAG_ORIGIN     = -32'sd134217728;
  localparam logic [30:0]        RESET_STEP_REAL       = 31'd262144;
  localparam logic [30:0]        RESET_STEP_IMAG       = 31'd262144;
  localparam logic [9:0]         RESET_ITERATION_LIMIT = 10'd200;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [4:0] LIMIT_ENTRY = 5'd16;

  typedef struct packed {
    logic signed [31:0] real_origin;
    logic signed [31:0] imag_origin;
    logic [30:0]        step_real;
    logic [30:0]        step_imag;
    logic [9:0]         iteration_limit;
  } mep_cfg_t;

  typedef struct packed {
    logic signed [31:0] cr;
    logic signed [31:0] ci;
  } mep_point_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mep_queue_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -65'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [23:0] palette(input logic [4:0] idx);
    logic [23:0] rgb;
    unique case (idx)
      5'd0:    rgb = {8'd66,  8'd30,  8'd15};
      5'd1:    rgb = {8'd25,  8'd7,   8'd26};
      5'd2:    rgb = {8'd9,   8'd1,   8'd47};
      5'd3:    rgb = {8'd4,   8'd4,   8'd73};
      5'd4:    rgb = {8'd0,   8'd7,   8'd100};
      5'd5:    rgb = {8'd12,  8'd44,  8'd138};
      5'd6:    rgb = {8'd24,  8'd82,  8'd177};
      5'd7:    rgb = {8'd57,  8'd125, 8'd209};
      5'd8:    rgb = {8'd134, 8'd181, 8'd229};
      5'd9:    rgb = {8'd211, 8'd236, 8'd248};
      5'd10:   rgb = {8'd241, 8'd233, 8'd191};
      5'd11:   rgb = {8'd248, 8'd201, 8'd95};
      5'd12:   rgb = {8'd255, 8'd170, 8'd0};
      5'd13:   rgb = {8'd204, 8'd128, 8'd0};
      5'd14:   rgb = {8'd153, 8'd87,  8'd0};
      5'd15:   rgb = {8'd106, 8'd52,  8'd3};
      default: rgb = {8'd16,  8'd16,  8'd16};
    endcase
    return rgb;
  endfunction

endpackage

/* src/mep_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_front
// Accepts pixel requests and maps them to a point c: multiply by the steps,
// then add the origins, saturate and snap a near-zero imaginary part.
// ----------------------------------------------------------------------------
module mep_front (
  input  logic                   clk,
  input  logic                   rst,
  input  mep_pkg::mep_cfg_t      cfg,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [11:0]            pixel_col,
  input  logic [11:0]            pixel_row,
  input  logic                   queue_full,
  output logic                   push,
  output mep_pkg::mep_point_t    point
);
  import mep_pkg::*;

  logic        prod_valid;
  logic [42:0] prod_re;
  logic [42:0] prod_im;

  logic signed [44:0] cr_exact;
  logic signed [44:0] ci_exact;
  logic [44:0]        ci_mag;
  logic               snap;
  logic               accept;

  assign in_stall = prod_valid & queue_full;
  assign accept   = in_valid & ~in_stall;
  assign push     = prod_valid & ~queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (accept) begin
      prod_valid <= 1'b1;
    end else if (push) begin
      prod_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_re <= 43'(pixel_col) * 43'(cfg.step_real);
      prod_im <= 43'(pixel_row) * 43'(cfg.step_imag);
    end
  end

  always_comb begin
    cr_exact = 45'(cfg.real_origin) + $signed({2'b00, prod_re});
    ci_exact = 45'(cfg.imag_origin) + $signed({2'b00, prod_im});
    ci_mag   = ci_exact[44] ? 45'(-ci_exact) : 45'(ci_exact);
    snap     = {ci_mag, 1'b0} < 46'(cfg.step_imag);
    point.cr = sat32(65'(cr_exact));
    point.ci = snap ? 32'sd0 : sat32(65'(ci_exact));
  end

endmodule

/* src/mep_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_queue
// Two-entry queue of points between the coordinate front and the
// iteration back.
// ----------------------------------------------------------------------------
module mep_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  mep_pkg::mep_point_t         push_data,
  input  logic                        pop,
  output mep_pkg::mep_point_t         pop_data,
  output mep_pkg::mep_queue_status_t  status
);
  import mep_pkg::*;

  mep_point_t             entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] fill;

  assign status.full  = fill == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign status.empty = fill == '0;
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

/* src/mep_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_back
// Shared square-and-add unit: alternates a multiply phase and an add phase
// per iteration, then looks up the colour into the result register.
// ----------------------------------------------------------------------------
module mep_back #(
  parameter int FRAC_BITS = 26
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [9:0]           iteration_limit,
  input  logic                 queue_empty,
  input  mep_pkg::mep_point_t  point,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue,
  output logic [9:0]           escape_count
);
  import mep_pkg::*;

  localparam logic [64:0] BOUND = 65'd1 << (2 * FRAC_BITS + 2);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD, S_DONE} state_t;

  state_t             state;
  logic signed [31:0] cr;
  logic signed [31:0] ci;
  logic signed [31:0] zr;
  logic signed [31:0] zi;
  logic signed [63:0] zr2;
  logic signed [63:0] zi2;
  logic signed [63:0] cross_term;
  logic [9:0]         count;

  logic signed [63:0] sq_re;
  logic signed [63:0] sq_im;
  logic signed [63:0] prod_ri;
  logic signed [63:0] diff;
  logic [64:0]        mag2;
  logic signed [64:0] zr_sum;
  logic signed [64:0] zi_sum;
  logic               keep_going;
  logic               out_free;
  logic               finish;
  logic [4:0]         pal_idx;
  logic [23:0]        rgb;

  assign sq_re      = zr * zr;
  assign sq_im      = zi * zi;
  assign prod_ri    = zr * zi;
  assign diff       = zr2 - zi2;
  assign mag2       = {1'b0, zr2} + {1'b0, zi2};
  assign zr_sum     = 65'(diff >>> FRAC_BITS) + 65'(cr);
  assign zi_sum     = 65'(cross_term >>> (FRAC_BITS - 1)) + 65'(ci);
  assign keep_going = (count < iteration_limit) && (mag2 < BOUND);
  assign out_free   = ~out_valid | ~out_stall;
  assign finish     = out_free & (((state == S_ADD) & ~keep_going) | (state == S_DONE));
  assign pal_idx    = (count == iteration_limit) ? LIMIT_ENTRY : {1'b0, count[3:0]};
  assign rgb        = palette(pal_idx);
  assign pop        = (state == S_IDLE) & ~queue_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!queue_empty) begin
            cr         <= point.cr;
            ci         <= point.ci;
            zr         <= '0;
            zi         <= '0;
            zr2        <= '0;
            zi2        <= '0;
            cross_term <= '0;
            count      <= '0;
            state      <= S_ADD;
          end
        end
        S_MUL: begin
          zr2        <= sq_re;
          zi2        <= sq_im;
          cross_term <= prod_ri;
          state      <= S_ADD;
        end
        S_ADD: begin
          if (keep_going) begin
            zr    <= sat32(zr_sum);
            zi    <= sat32(zi_sum);
            count <= count + 1'b1;
            state <= S_MUL;
          end else if (out_free) begin
            red          <= rgb[23:16];
            green        <= rgb[15:8];
            blue         <= rgb[7:0];
            escape_count <= count;
            state        <= S_IDLE;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            red          <= rgb[23:16];
            green        <= rgb[15:8];
            blue         <= rgb[7:0];
            escape_count <= count;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/mandelbrot_escape_pixel_color.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_color
// Escape-time colouring of one pixel per request: coordinate front, point
// queue, shared square-and-add back end, palette lookup.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   pixel_col, pixel_row
//   out      output     out_valid / out_stall red, green, blue, escape_count
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// A pixel that escapes after n iterations passes the front's product
// register and the queue, then a multiply state and an add state per
// iteration in the shared square-and-add unit, plus load and result steps.
// Reset loads the default view and an iteration limit of 200, empties the queue.
// The queue holds two points, so the front takes up to three requests ahead of
// the back; a stalled result holds the back in its finished state.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_color #(
  parameter int FRAC_BITS = 26
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] pixel_col,
  input  logic [11:0] pixel_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [9:0]  escape_count
);
  import mep_pkg::*;

  mep_cfg_t          cfg;
  mep_point_t        push_point;
  mep_point_t        pop_point;
  mep_queue_status_t q_stat;
  logic              push;
  logic              pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.real_origin     <= RESET_REAL_ORIGIN;
      cfg.imag_origin     <= RESET_IMAG_ORIGIN;
      cfg.step_real       <= RESET_STEP_REAL;
      cfg.step_imag       <= RESET_STEP_IMAG;
      cfg.iteration_limit <= RESET_ITERATION_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REAL_ORIGIN:     cfg.real_origin     <= cfg_data;
        REG_IMAG_ORIGIN:     cfg.imag_origin     <= cfg_data;
        REG_STEP_REAL:       cfg.step_real       <= cfg_data[30:0];
        REG_STEP_IMAG:       cfg.step_imag       <= cfg_data[30:0];
        REG_ITERATION_LIMIT: cfg.iteration_limit <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  mep_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_col  (pixel_col),
    .pixel_row  (pixel_row),
    .queue_full (q_stat.full),
    .push       (push),
    .point      (push_point)
  );

  mep_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_point),
    .pop       (pop),
    .pop_data  (pop_point),
    .status    (q_stat)
  );

  mep_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .iteration_limit (cfg.iteration_limit),
    .queue_empty     (q_stat.empty),
    .point           (pop_point),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .red             (red),
    .green           (green),
    .blue            (blue),
    .escape_count    (escape_count)
  );

`ifndef SYNTHESIS
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");
  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_stat.full)
    else $error("request stalled while queue has room");
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");
  a_zero_count_colour: assert property (@(posedge clk) disable iff (rst)
    (out_valid && escape_count == 10'd0) |->
      (red == 8'd16 && green == 8'd16 && blue == 8'd16))
    else $error("zero count without limit colour");
`endif

endmodule

/* test/mandelbrot_escape_pixel_color_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_color_tb
// Drives pixel requests through several views and iteration limits: the
// reset view, the imaginary snap-to-zero band, zero, one and full limits,
// saturated coordinates, a long output hold that backs up the input, and
// random views. Each result is compared with an escape-time predictor kept
// in the bench.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_color_tb;
  import mep_pkg::*;

  localparam int FRAC = 26;
  localparam longint unsigned ESCAPE_BOUND = 64'd4 << (2 * FRAC);
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] escape_count;
  } pixel_color_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [31:0] cfg_data = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] pixel_col = 12'd0;
  logic [11:0] pixel_row = 12'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [9:0]  escape_count;

  logic signed [31:0] view_real = RESET_REAL_ORIGIN;
  logic signed [31:0] view_imag = RESET_IMAG_ORIGIN;
  logic [30:0]        step_re = RESET_STEP_REAL;
  logic [30:0]        step_im = RESET_STEP_IMAG;
  logic [9:0]         iter_limit = RESET_ITERATION_LIMIT;

  logic [23:0] color_table [0:16] = '{
    {8'd66, 8'd30, 8'd15},    {8'd25, 8'd7, 8'd26},     {8'd9, 8'd1, 8'd47},
    {8'd4, 8'd4, 8'd73},      {8'd0, 8'd7, 8'd100},     {8'd12, 8'd44, 8'd138},
    {8'd24, 8'd82, 8'd177},   {8'd57, 8'd125, 8'd209},  {8'd134, 8'd181, 8'd229},
    {8'd211, 8'd236, 8'd248}, {8'd241, 8'd233, 8'd191}, {8'd248, 8'd201, 8'd95},
    {8'd255, 8'd170, 8'd0},   {8'd204, 8'd128, 8'd0},   {8'd153, 8'd87, 8'd0},
    {8'd106, 8'd52, 8'd3},    {8'd16, 8'd16, 8'd16}
  };

  pixel_color_t pending_colors [$];
  int           mismatch_count = 0;
  int           idle_pct = 18;
  int           stall_pct = 18;
  logic         hold_req = 1'b0;
  int           hold_left = 0;
  longint       cycle_count = 0;
  longint       run_budget = 100000;

  mandelbrot_escape_pixel_color dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_col    (pixel_col),
    .pixel_row    (pixel_row),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .escape_count (escape_count)
  );

  always #10 clk = ~clk;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic pixel_color_t escape_color(input logic [11:0] col,
                                                input logic [11:0] row);
    longint          cr, ci, ci_exact, mag, zr, zi, cross_term, diff;
    longint unsigned zr2, zi2;
    int unsigned     n, entry;
    pixel_color_t    res;
    cr = clamp32(longint'(view_real) + longint'(col) * longint'(step_re));
    ci_exact = longint'(view_imag) + longint'(row) * longint'(step_im);
    mag = (ci_exact < 0) ? -ci_exact : ci_exact;
    ci = clamp32(ci_exact);
    if (2 * mag < longint'(step_im)) ci = 0;
    zr = 0;
    zi = 0;
    zr2 = 0;
    zi2 = 0;
    n = 0;
    while (n < iter_limit && zr2 + zi2 < ESCAPE_BOUND) begin
      cross_term = zr * zi;
      diff = longint'(zr2) - longint'(zi2);
      zi = clamp32((cross_term >>> (FRAC - 1)) + ci);
      zr = clamp32((diff >>> FRAC) + cr);
      zr2 = zr * zr;
      zi2 = zi * zi;
      n++;
    end
    entry = (n == iter_limit) ? 16 : n % 16;
    res.red = color_table[entry][23:16];
    res.green = color_table[entry][15:8];
    res.blue = color_table[entry][7:0];
    res.escape_count = n[9:0];
    return res;
  endfunction

  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    pixel_col <= col;
    pixel_row <= row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_colors.push_back(escape_color(col, row));
    run_budget += 3 * (2 * longint'(iter_limit) + 8) + 40;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
  endtask

  // Write all five registers back to back; junk goes in the unused data bits.
  task automatic load_view(input logic signed [31:0] ro, input logic signed [31:0] io,
                           input logic [30:0] sr, input logic [30:0] si,
                           input logic [9:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= REG_REAL_ORIGIN;
    cfg_data  <= ro;
    @(posedge clk);
    cfg_index <= REG_IMAG_ORIGIN;
    cfg_data  <= io;
    @(posedge clk);
    cfg_index <= REG_STEP_REAL;
    cfg_data  <= {1'($urandom_range(1)), sr};
    @(posedge clk);
    cfg_index <= REG_STEP_IMAG;
    cfg_data  <= {1'($urandom_range(1)), si};
    @(posedge clk);
    cfg_index <= REG_ITERATION_LIMIT;
    cfg_data  <= {22'($urandom), lim};
    @(posedge clk);
    cfg_we <= 1'b0;
    view_real  = ro;
    view_imag  = io;
    step_re    = sr;
    step_im    = si;
    iter_limit = lim;
  endtask

  task automatic test_reset_view();
    send_pixel(0, 0);
    send_pixel(640, 512);
    send_pixel(448, 512);
    send_pixel(704, 512);
    send_pixel(4095, 4095);
    send_pixel(4095, 0);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(600, 700);
    wait_drained();
  endtask

  task automatic test_imag_snap();
    load_view(RESET_REAL_ORIGIN, RESET_IMAG_ORIGIN + 32'sd100000,
              RESET_STEP_REAL, RESET_STEP_IMAG, 10'd100);
    send_pixel(704, 512);
    send_pixel(704, 511);
    wait_drained();
    // exactly half a row away stays unsnapped
    load_view(RESET_REAL_ORIGIN, RESET_IMAG_ORIGIN + 32'sd131072,
              RESET_STEP_REAL, RESET_STEP_IMAG, 10'd100);
    send_pixel(704, 512);
    wait_drained();
  endtask

  task automatic test_limit_extremes();
    load_view(RESET_REAL_ORIGIN, RESET_IMAG_ORIGIN, RESET_STEP_REAL, RESET_STEP_IMAG, 10'd0);
    send_pixel(640, 512);
    send_pixel(0, 0);
    wait_drained();
    load_view(RESET_REAL_ORIGIN, RESET_IMAG_ORIGIN, RESET_STEP_REAL, RESET_STEP_IMAG, 10'd1);
    send_pixel(640, 512);
    send_pixel(0, 0);
    wait_drained();
    load_view(RESET_REAL_ORIGIN, RESET_IMAG_ORIGIN, RESET_STEP_REAL, RESET_STEP_IMAG,
              10'd1023);
    send_pixel(640, 512);
    wait_drained();
  endtask

  task automatic test_coordinate_saturation();
    load_view(32'sh7fffffff, 32'sh80000000, 31'h7fffffff, 31'h7fffffff, 10'd50);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    send_pixel(4095, 4095);
    wait_drained();
    load_view(32'sh80000000, 32'sd0, 31'd0, 31'd0, 10'd50);
    send_pixel(0, 0);
    send_pixel(12'h800, 12'h800);
    wait_drained();
  endtask

  task automatic test_output_hold();
    load_view(RESET_REAL_ORIGIN, RESET_IMAG_ORIGIN, RESET_STEP_REAL, RESET_STEP_IMAG, 10'd24);
    idle_pct = 0;
    hold_req <= 1'b1;
    for (int i = 0; i < 16; i++) begin
      send_pixel(12'($urandom_range(900)), 12'($urandom_range(1023)));
    end
    wait_drained();
    idle_pct = 18;
  endtask

  task automatic test_random_views();
    int                 k, span_c, span_r;
    logic signed [31:0] ro, io;
    logic [30:0]        sr, si;
    logic [9:0]         lim;
    for (int p = 0; p < 8; p++) begin
      k = $urandom_range(14, 20);
      sr = (31'd1 << k) + 31'($urandom_range(1 << (k - 4)));
      si = (31'd1 << k) + 31'($urandom_range(1 << (k - 4)));
      ro = RESET_REAL_ORIGIN + 32'($urandom_range(1 << 26));
      io = RESET_IMAG_ORIGIN + 32'($urandom_range(1 << 25));
      lim = 10'($urandom_range(8, 255));
      span_c = (7 << (25 - k)) > 4096 ? 4096 : (7 << (25 - k));
      span_r = (3 << (26 - k)) > 4096 ? 4096 : (3 << (26 - k));
      if (p == 3) begin
        ro = $urandom;
        io = $urandom;
        sr = 31'($urandom);
        si = 31'($urandom);
        lim = 10'($urandom_range(0, 1023));
        span_c = 4096;
        span_r = 4096;
      end else if (p == 6) begin
        // every pixel lands on one point
        sr = 31'd0;
        si = 31'd0;
        lim = 10'($urandom_range(8, 64));
        span_c = 4096;
        span_r = 4096;
      end
      load_view(ro, io, sr, si, lim);
      if (p == 2) begin
        idle_pct = 0;
        stall_pct = 0;
      end
      for (int i = 0; i < 208; i++) begin
        if ($urandom_range(3) != 0) begin
          send_pixel(12'($urandom_range(span_c - 1)), 12'($urandom_range(span_r - 1)));
        end else begin
          send_pixel(12'($urandom), 12'($urandom));
        end
      end
      wait_drained();
      idle_pct = 18;
      stall_pct = 18;
    end
  endtask

  always @(posedge clk) begin : color_check
    pixel_color_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_colors.size() == 0) begin
        $error("result with no request pending: escape_count %0d", escape_count);
        mismatch_count++;
      end else begin
        want = pending_colors.pop_front();
        if (red !== want.red) begin
          $error("red expected %0d got %0d", want.red, red);
          mismatch_count++;
        end
        if (green !== want.green) begin
          $error("green expected %0d got %0d", want.green, green);
          mismatch_count++;
        end
        if (blue !== want.blue) begin
          $error("blue expected %0d got %0d", want.blue, blue);
          mismatch_count++;
        end
        if (escape_count !== want.escape_count) begin
          $error("escape_count expected %0d got %0d", want.escape_count, escape_count);
          mismatch_count++;
        end
      end
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_req  <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > run_budget) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_view();
    test_imag_snap();
    test_limit_extremes();
    test_coordinate_saturation();
    test_output_hold();
    test_random_views();
    wait_drained();
    repeat (2 * int'(iter_limit) + 32) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
